@@ hw/rtl/signed_int_to_radix_ascii_top_macros.svh @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii_top_macros.svh
// assertion macros for the radix conversion rtl (used by sira_back)
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_RADIX_ASCII_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIRA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sira assertion failed");

// next-cycle implication, checked outside reset
`define SIRA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sira assertion failed");

`endif

@@ hw/rtl/sira_pkg.sv @@
// ----------------------------------------------------------------------------
// sira_pkg
// shared constants, config struct and digit encoding for the radix converter
// ----------------------------------------------------------------------------
package sira_pkg;

    // default operand width and fixed sizes
    localparam int VALUE_BITS_DEF      = 64;
    localparam int BUFFER_DEPTH        = 64;
    localparam int QUEUE_DEPTH         = 2;
    localparam int DIV_BITS_PER_CYCLE  = 8;

    // register fields
    localparam logic [5:0] RADIX_MIN    = 6'd2;
    localparam logic [5:0] RADIX_MAX    = 6'd36;
    localparam logic [5:0] RADIX_RESET  = 6'd10;
    localparam logic [6:0] BUFLEN_RESET = 7'd64;
    localparam logic [6:0] CAP_MAX      = 7'(BUFFER_DEPTH);

    // register index, taken from the word address
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_BUFLEN = 1'b1;

    // character codes
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_LETTER_A = 8'h41;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_NONE     = 8'h00;
    localparam logic [5:0] DIGIT_TEN     = 6'hA;

    // effective conversion settings after saturation
    typedef struct packed {
        logic [5:0] base;
        logic [6:0] cap;
    } t_cfg;

    // digit value to ascii
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [5:0] off;
        off = d - DIGIT_TEN;
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + {2'b00, d};
        end
        return CHAR_LETTER_A + {2'b00, off};
    endfunction

endpackage

@@ hw/rtl/sira_front.sv @@
// ----------------------------------------------------------------------------
// sira_front
// input side: accepts a value, splits it into sign and unsigned magnitude
// ----------------------------------------------------------------------------
module sira_front
    import sira_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_tvalid,
    output logic                  o_tready,
    input  logic [63:0]           i_tdata,
    input  logic                  i_full,
    output logic                  o_push,
    output logic [VALUE_BITS:0]   o_item
);

    logic [VALUE_BITS-1:0] w_val;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;

    // sign from the top used bit, magnitude exact for the most negative value
    assign w_val = i_tdata[VALUE_BITS-1:0];
    assign w_neg = w_val[VALUE_BITS-1];
    assign w_mag = w_neg ? (~w_val + VALUE_BITS'(1)) : w_val;

    // transaction handshake into the queue
    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign o_item   = {w_neg, w_mag};

endmodule

@@ hw/rtl/sira_queue.sv @@
// ----------------------------------------------------------------------------
// sira_queue
// short fifo between the classifying front and the converting back
// ----------------------------------------------------------------------------
module sira_queue
    import sira_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/sira_back.sv @@
// ----------------------------------------------------------------------------
// sira_back
// converter: shared digit divider, digit store and character output register
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_ascii_top_macros.svh"

module sira_back
    import sira_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  logic [VALUE_BITS:0] i_q_data,
    output logic                o_q_pop,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [7:0]          o_char,
    output logic                o_last,
    output logic                o_err
);

    localparam int DIV_CYC = (VALUE_BITS + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int WORK_W  = DIV_CYC * DIV_BITS_PER_CYCLE;
    localparam int STEP_W  = $clog2(DIV_CYC + 1);
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int IDX_W   = $clog2(VALUE_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [WORK_W-1:0] r_work,  n_work;
    logic [5:0]        r_rem,   n_rem;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic              r_neg,   n_neg;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic              r_first, n_first;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_char,  n_char;
    logic              r_last,  n_last;
    logic              r_err,   n_err;
    logic [5:0]        r_rdata;
    logic [5:0]        r_store [VALUE_BITS];

    logic [WORK_W-1:0] d_work;
    logic [5:0]        d_rem;
    logic [6:0]        d_t;
    logic              w_last_step;
    logic              w_store_we;
    logic [7:0]        w_total;
    logic              w_overflow;

    // eight restoring steps of the digit division per cycle
    always_comb begin
        d_work = r_work;
        d_rem  = r_rem;
        d_t    = '0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            d_t    = {d_rem, d_work[WORK_W-1]};
            d_work = {d_work[WORK_W-2:0], 1'b0};
            if (d_t >= {1'b0, i_cfg.base}) begin
                d_rem     = 6'(d_t - {1'b0, i_cfg.base});
                d_work[0] = 1'b1;
            end else begin
                d_rem = d_t[5:0];
            end
        end
    end

    assign w_last_step = (r_step == STEP_W'(DIV_CYC - 1));
    assign w_store_we  = (r_state == S_DIV) && w_last_step;

    // text length check, sign counted, one slot kept for the terminator
    assign w_total    = 8'(r_cnt) + 8'(r_neg);
    assign w_overflow = (w_total >= {1'b0, i_cfg.cap});

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_tvalid = r_ovalid;
    assign o_char   = r_char;
    assign o_last   = r_last;
    assign o_err    = r_err;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_work   = r_work;
        n_rem    = r_rem;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_idx    = r_idx;
        n_first  = r_first;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        n_err    = r_err;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_neg   = i_q_data[VALUE_BITS];
                    n_work  = WORK_W'(i_q_data[VALUE_BITS-1:0]);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_work = d_work;
                n_rem  = d_rem;
                n_step = r_step + STEP_W'(1);
                if (w_last_step) begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rem  = '0;
                    n_step = '0;
                    if (d_work == '0) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_idx = IDX_W'(r_cnt - CNT_W'(1));
                if (w_overflow) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_NONE;
                    n_last   = 1'b1;
                    n_err    = 1'b1;
                    n_state  = S_OUT;
                end else if (r_neg) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = (w_total == 8'd1);
                    n_err    = 1'b0;
                    n_first  = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_first = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_ovalid = 1'b1;
                n_char   = digit_char(r_rdata);
                n_last   = (r_idx == '0);
                n_err    = 1'b0;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_tready) begin
                    n_ovalid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else if (r_first) begin
                        n_first = 1'b0;
                        n_state = S_RD;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_step   <= '0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_first  <= n_first;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
        r_err  <= n_err;
    end

    // digit store, least significant digit first, registered read
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_cnt[IDX_W-1:0]] <= d_rem;
        end
        r_rdata <= r_store[r_idx];
    end

    // checks
    `SIRA_ASSERT_IMPL(a_out_only_in_out_state, i_clk, i_rst_n, r_ovalid, r_state == S_OUT)
    `SIRA_ASSERT_IMPL(a_error_is_last, i_clk, i_rst_n, r_ovalid && r_err, r_last)
    `SIRA_ASSERT_IMPL(a_count_bounded, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(VALUE_BITS))
    `SIRA_ASSERT_NEXT(a_pop_starts_div, i_clk, i_rst_n, o_q_pop, r_state == S_DIV)

endmodule

@@ hw/rtl/signed_int_to_radix_ascii_top.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii_top
// signed integer to ascii text in a programmable radix, one character per beat
// ----------------------------------------------------------------------------
// flow: the converter takes one value at a time, a 2-entry queue takes inputs
//   meanwhile; each value is divided into digits, then an error result goes out as
//   a single character, or else a minus sign where due and the digits, most
//   significant first
// reset: radix 10, buffer length 64, queue and output empty, no store clearing

module signed_int_to_radix_ascii_top
    import sira_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] error
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0]          r_radix;
    logic [6:0]          r_buflen;
    t_cfg                w_cfg;
    logic                w_cfg_we;
    logic                w_full;
    logic                w_push;
    logic [VALUE_BITS:0] w_push_item;
    logic                w_q_valid;
    logic                w_q_pop;
    logic [VALUE_BITS:0] w_q_item;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_buflen <= BUFLEN_RESET;
        end else if (w_cfg_we) begin
            case (paddr[2])
                REG_RADIX:  r_radix  <= pwdata[5:0];
                REG_BUFLEN: r_buflen <= pwdata[6:0];
                default:    r_radix  <= r_radix;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RADIX:  prdata = {26'd0, r_radix};
            REG_BUFLEN: prdata = {25'd0, r_buflen};
            default:    prdata = '0;
        endcase
    end

    // saturated radix and capacity
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_cfg.base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_cfg.base = RADIX_MAX;
        end else begin
            w_cfg.base = r_radix;
        end
        w_cfg.cap = (r_buflen > CAP_MAX) ? CAP_MAX : r_buflen;
    end

    // front: sign and magnitude
    sira_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // queue between front and back
    sira_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_item)
    );

    // back: digits and characters
    sira_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_err     (m_axis_tuser)
    );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the signed integer to radix ascii converter: feeds
// signed 64-bit values over the input stream, programs radix and buffer length
// over apb, predicts the character stream of every value and checks each
// output transaction field by field against it
// ----------------------------------------------------------------------------
module tb
    import sira_pkg::*;
();

    localparam int          RUN_LIMIT   = 2_000_000;
    localparam int          STALL_LEN   = 400;
    localparam int          TAIL_CYCLES = 40;
    localparam logic [2:0]  ADDR_RADIX  = {REG_RADIX, 2'b00};
    localparam logic [2:0]  ADDR_BUFLEN = {REG_BUFLEN, 2'b00};
    localparam logic [63:0] INT_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    // one output character transaction
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_text_beat;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata   = '0;   // [63:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] character
    logic        m_axis_tlast;
    logic        m_axis_tuser;          // [0] error
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // converter settings as last written
    logic [5:0]  radix_reg      = RADIX_RESET;
    logic [6:0]  buflen_reg     = BUFLEN_RESET;

    t_text_beat  pending_chars[$];
    int          mismatch_count = 0;
    int          values_sent    = 0;
    int          chars_checked  = 0;
    int          overflows_seen = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    int          hold_left      = 0;

    signed_int_to_radix_ascii_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // expected characters of one value under the current settings
    function automatic void predict_text(input logic [63:0] v);
        logic [63:0] base;
        logic [63:0] mag;
        logic [6:0]  cap;
        logic [5:0]  digits [BUFFER_DEPTH];
        logic [7:0]  ch;
        logic        neg;
        int          ndig;
        int          total;
        base = (radix_reg < RADIX_MIN) ? 64'(RADIX_MIN) :
               (radix_reg > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(radix_reg);
        cap  = (buflen_reg > CAP_MAX) ? CAP_MAX : buflen_reg;
        neg  = v[63];
        // magnitude as unsigned, exact for the most negative value too
        mag  = neg ? (~v + 64'd1) : v;
        ndig = 0;
        do begin
            digits[ndig] = 6'(mag % base);
            mag          = mag / base;
            ndig++;
        end while (mag != 0 && ndig < BUFFER_DEPTH);
        total = ndig + int'(neg);
        // sign counts against the room left beside the terminator
        if (cap == 0 || total > int'(cap) - 1) begin
            pending_chars.push_back(t_text_beat'{CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        if (neg) begin
            pending_chars.push_back(t_text_beat'{CHAR_MINUS, total == 1, 1'b0});
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            ch = (digits[k] < DIGIT_TEN) ? CHAR_ZERO + 8'(digits[k])
                                         : CHAR_LETTER_A + 8'(digits[k] - DIGIT_TEN);
            pending_chars.push_back(t_text_beat'{ch, k == 0, 1'b0});
        end
    endfunction

    task automatic note_mismatch(input string what, input t_text_beat want,
                                 input t_text_beat got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %0d, %s: expected char %h last %b error %b, got char %h last %b error %b",
                     mismatch_count, what, want.ch, want.last, want.err,
                     got.ch, got.last, got.err);
        end
    endtask

    // output side: random ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (stall_served != stall_requests) begin
            stall_served  <= stall_requests;
            hold_left     <= STALL_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare every output transaction with the oldest expected character
    always @(posedge i_clk) begin : check_beat
        t_text_beat got;
        t_text_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_text_beat'{m_axis_tdata, m_axis_tlast, m_axis_tuser};
            if (pending_chars.size() == 0) begin
                note_mismatch("no character expected", '0, got);
            end else begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch) note_mismatch("character", want, got);
                else if (got.last !== want.last) note_mismatch("last", want, got);
                else if (got.err !== want.err) note_mismatch("error flag", want, got);
                if (want.err) overflows_seen++;
                else chars_checked++;
            end
        end
    end

    // one value over the input stream, with a random gap in front
    task automatic send_value(input logic [63:0] v);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_text(v);
        values_sent++;
    endtask

    // stop offering and wait until every expected character has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIX) radix_reg = data[5:0];
        else buflen_reg = data[6:0];
    endtask

    task automatic set_config(input int radix, input int buflen);
        wait_drained();
        apb_write(ADDR_RADIX, 32'(radix));
        apb_write(ADDR_BUFLEN, 32'(buflen));
    endtask

    // value mix: full range, small, random bit length, boundaries
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        int          w;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: v = 64'($urandom_range(0, 200));
            2: begin
                w = $urandom_range(1, 64);
                v = v >> (64 - w);
            end
            default: begin
                case ($urandom_range(4))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = '0;
                    3: v = 64'd1 << $urandom_range(0, 62);
                    default: v = 64'(radix_reg) ** $urandom_range(0, 12);
                endcase
            end
        endcase
        if ($urandom_range(1)) v = ~v + 64'd1;
        return v;
    endfunction

    // settings straight out of reset
    task automatic test_reset_defaults();
        send_value(64'd0);
        send_value(64'd1);
        send_value(~64'd0);
        send_value(INT_MAX);
        send_value(INT_MIN);
        send_value(64'd10);
        wait_drained();
    endtask

    // binary and base 36, plus radix values outside the legal range
    task automatic test_radix_extremes();
        set_config(2, 64);
        send_value(INT_MAX);            // 63 ones, fills the buffer exactly
        send_value(INT_MIN);            // sign plus 64 digits, overflows
        send_value(~64'd0);
        set_config(36, 64);
        send_value(64'd35);
        send_value(-64'sd36);
        set_config(0, 64);              // saturates to binary
        send_value(64'd5);
        set_config(63, 64);             // saturates to base 36
        send_value(64'd71);
        set_config(16, 64);
        send_value(64'hDEAD_BEEF_0123_4567);
        wait_drained();
    endtask

    // zero, one and tiny buffers, and a length above the store depth
    task automatic test_buffer_limits();
        set_config(10, 0);
        send_value(64'd0);
        set_config(10, 1);
        send_value(64'd0);
        set_config(10, 2);
        send_value(64'd7);
        send_value(-64'sd7);
        set_config(10, 3);
        send_value(-64'sd7);
        send_value(64'd100);
        set_config(10, 127);
        send_value(INT_MIN);
        wait_drained();
    endtask

    // random values under changing settings
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int n_values);
        int radix;
        int buflen;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int i = 0; i < n_values; i++) begin
            if (i % 40 == 0) begin
                radix  = ($urandom_range(99) < 85) ? $urandom_range(2, 36)
                                                   : $urandom_range(0, 63);
                buflen = ($urandom_range(99) < 10) ? $urandom_range(0, 127)
                                                   : $urandom_range(16, 64);
                set_config(radix, buflen);
            end
            send_value(rand_value());
        end
        wait_drained();
    endtask

    // output held off while values keep coming, so the input stalls
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        set_config(10, 64);
        stall_requests <= stall_requests + 1;
        for (int i = 0; i < 8; i++) send_value({$urandom, $urandom});
        wait_drained();
    endtask

    // input pauses until the converter has emptied, then resumes
    task automatic test_drain_pause();
        send_idle_pct = 26;
        recv_idle_pct <= 50;
        for (int i = 0; i < 4; i++) send_value(rand_value());
        wait_drained();
        for (int i = 0; i < 4; i++) send_value(rand_value());
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 26;
        recv_idle_pct <= 50;
        test_reset_defaults();
        test_radix_extremes();
        test_buffer_limits();
        test_output_holdoff();
        test_drain_pause();
        test_random_phase(26, 50, 145);
        test_random_phase(50, 26, 145);
        test_random_phase(0, 0, 145);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("converted %0d values: %0d characters and %0d overflow results checked",
                 values_sent, chars_checked, overflows_seen);
        $display("radix swept 0..63 and buffer length 0..127, with stalls on both streams");
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
